// ===== sv/polynomial_term_store_assert.svh =====
// Assertion macros for the polynomial term store.
// Used by the top level only; expects clk and rst in scope.
`ifndef POLYNOMIAL_TERM_STORE_ASSERT_SVH
`define POLYNOMIAL_TERM_STORE_ASSERT_SVH

// same-cycle implication
`define PTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polynomial_term_store: same-cycle check failed");

// next-cycle implication
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polynomial_term_store: next-cycle check failed");

`endif

// ===== sv/pts_pkg.sv =====
// Shared constants and types for the polynomial term store.
// No dependencies.
package pts_pkg;

  localparam int MAX_DEGREE_DEF = 63;
  localparam int COEFF_BITS_DEF = 32;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_READ   = 3'd1,
    ACT_EVAL   = 3'd2,
    ACT_DERIVE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WIPE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

// ===== sv/pts_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies. Read during write to the same address returns old data.
module pts_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/polynomial_term_store.sv =====
// Polynomial term store: one integer polynomial held as a dense coefficient
// table in a single RAM (MAX_DEGREE+1 words of COEFF_BITS bits). Every command
// (add term, read, evaluate by Horner's rule, derive in place, clear; codes 5-7
// change nothing) is one sweep over the whole table from the top degree down,
// one word per cycle unless an evaluate works in slices (see below). A command
// reads every word of the table, waits out the RAM read latency, loads the
// result registers and raises done as it returns to idle. The sweep is set
// by the single RAM read port. For COEFF_BITS above 32 the evaluate
// multiplier works in 16-bit slices of x, and each word of an evaluate then
// holds the sweep until all of its slices are in. After reset the block
// clears every word of the RAM with busy high. Each command yields exactly
// one result word, shown for one cycle with done high; the receiver cannot
// stall it.
// depends on: pts_pkg, pts_ram, polynomial_term_store_assert.svh
module polynomial_term_store
  import pts_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [5:0]         degree_sel,
  input  logic signed [31:0] term_coeff,
  input  logic signed [31:0] x_value,
  output logic               done,
  output logic signed [31:0] value,
  output logic [6:0]         term_count,
  output logic signed [6:0]  top_degree,
  output logic               is_zero
);

  `include "polynomial_term_store_assert.svh"

  localparam int W     = COEFF_BITS;
  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  // multiplier slice of x per cycle during evaluate
  localparam int CH    = (W <= 32) ? W : 16;
  localparam int K     = (W + CH - 1) / CH;
  localparam int PW    = (K > 1) ? $clog2(K) : 1;
  localparam int MW    = W + CH;
  localparam int DW    = W + AW;

  // control
  state_t          state;
  logic [AW-1:0]   wipe_idx;   // reset clearing pass
  logic [AW-1:0]   idx;        // next address to read
  logic            issue_done; // every address of the sweep has been read
  logic            rd_pend;    // rdata holds word pidx, not yet retired
  logic [AW-1:0]   pidx;
  logic [PW-1:0]   part;       // slice count inside one Horner step

  // latched command
  logic [2:0]      op;
  logic [5:0]      deg;
  logic [W-1:0]    term;
  logic [W-1:0]    xw;

  // datapath
  logic [W-1:0]    acc;
  logic [W-1:0]    mcand;
  logic [W-1:0]    mplier;
  logic [W-1:0]    psum;
  logic [W-1:0]    rd_val;
  logic [CW-1:0]   cnt;
  logic            found;
  logic [AW-1:0]   top;

  // RAM port
  logic            we;
  logic [AW-1:0]   waddr;
  logic [W-1:0]    wdata;
  logic            re;
  logic [W-1:0]    rdata;

  // sweep combinational
  logic            step_done;
  logic            first;
  logic            hit;
  logic            post_en;
  logic [AW-1:0]   post_idx;
  logic [W-1:0]    post;
  logic [DW-1:0]   dprod;
  logic [MW-1:0]   mprod;
  logic [W-1:0]    new_acc;
  logic signed [63:0] x64;
  logic signed [63:0] t64;
  logic signed [W-1:0] fin;
  logic signed [63:0] fin64;

  pts_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH),
    .ADDR_BITS (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx),
    .rdata (rdata)
  );

  assign busy = (state != ST_IDLE);

  assign x64 = 64'(x_value);
  assign t64 = 64'(term_coeff);

  // a Horner step retires once its last slice is in; other commands retire a word as soon as it is read back
  assign step_done = rd_pend && ((op != ACT_EVAL) || (part == PW'(K - 1)));
  assign first     = (state == ST_SWEEP) && !rd_pend && !issue_done &&
                     (idx == AW'(MAX_DEGREE));
  assign re        = (state == ST_SWEEP) && !issue_done && (!rd_pend || step_done);
  assign hit       = (32'(pidx) == 32'(deg));

  assign dprod   = DW'(rdata) * DW'(pidx);
  assign mprod   = MW'(mcand) * MW'(mplier[CH-1:0]);
  assign new_acc = psum + mprod[W-1:0] + rdata;

  // post-command contents of the word retired this cycle, and its write-back
  always_comb begin
    post_en  = 1'b1;
    post_idx = pidx;
    post     = rdata;
    we       = 1'b0;
    case (op)
      ACT_ADD: begin
        if (hit) begin
          post = rdata + term;
          we   = step_done;
        end
      end
      ACT_DERIVE: begin
        // word d lands in d-1 scaled by d; the constant term falls off
        post_en  = (pidx != '0);
        post_idx = pidx - AW'(1);
        post     = dprod[W-1:0];
        we       = step_done && (pidx != '0);
      end
      ACT_CLEAR: begin
        post = '0;
        we   = step_done;
      end
      default: begin
      end
    endcase
    waddr = post_idx;
    wdata = post;
    // derive empties the top word before any reads return; read-first keeps
    // the old top value for the first step
    if (first && (op == ACT_DERIVE)) begin
      we    = 1'b1;
      waddr = AW'(MAX_DEGREE);
      wdata = '0;
    end
    if (state == ST_WIPE) begin
      we    = 1'b1;
      waddr = wipe_idx;
      wdata = '0;
    end
  end

  always_comb begin
    case (op)
      ACT_EVAL: fin = acc;
      ACT_READ: fin = rd_val;
      default:  fin = '0;
    endcase
  end
  assign fin64 = 64'(fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WIPE;
      wipe_idx   <= '0;
      rd_pend    <= 1'b0;
      issue_done <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_WIPE: begin
          wipe_idx <= wipe_idx + AW'(1);
          if (wipe_idx == AW'(MAX_DEGREE)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op         <= action;
            deg        <= degree_sel;
            term       <= t64[W-1:0];
            xw         <= x64[W-1:0];
            idx        <= AW'(MAX_DEGREE);
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            part       <= '0;
            acc        <= '0;
            mcand      <= '0;
            mplier     <= x64[W-1:0];
            psum       <= '0;
            cnt        <= '0;
            found      <= 1'b0;
            top        <= '0;
            rd_val     <= '0;
            state      <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          // read issue, overlapped with retiring the previous word
          if (re) begin
            rd_pend <= 1'b1;
            pidx    <= idx;
            if (idx == '0) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx - AW'(1);
            end
          end else if (step_done) begin
            rd_pend <= 1'b0;
          end
          // Horner step, one slice of x per cycle
          if (rd_pend && (op == ACT_EVAL)) begin
            if (step_done) begin
              acc    <= new_acc;
              mcand  <= new_acc;
              mplier <= xw;
              psum   <= '0;
              part   <= '0;
            end else begin
              mcand  <= mcand << CH;
              mplier <= mplier >> CH;
              psum   <= psum + mprod[W-1:0];
              part   <= part + PW'(1);
            end
          end
          if (step_done) begin
            if (post_en && (post != '0)) begin
              cnt <= cnt + CW'(1);
              if (!found) begin
                found <= 1'b1;
                top   <= post_idx;
              end
            end
            if ((op == ACT_READ) && hit) begin
              rd_val <= rdata;
            end
            if (pidx == '0) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          value      <= fin64[31:0];
          term_count <= (32'(cnt) > 32'd127) ? 7'd127 : 7'(cnt);
          top_degree <= found ? 7'(top) : 7'h7f;
          is_zero    <= !found;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `PTS_ASSERT_NEXT(a_done_single, done, !done)
  `PTS_ASSERT_NOW(a_done_after_sweep, done, $past(state) == ST_DONE)
  `PTS_ASSERT_NOW(a_pend_in_sweep, rd_pend, state == ST_SWEEP)
  `PTS_ASSERT_NOW(a_zero_flags, done, (is_zero == (term_count == 7'd0)) &&
                  (!is_zero || (top_degree == 7'h7f)))

endmodule
